// ===== rtl/sqp_pkg.sv =====
`default_nettype none
package sqp_pkg;

  // Sample width and derived datapath widths
  localparam int SAMPLE_WIDTH    = 16;
  localparam int CFG_WIDTH       = 16;
  localparam int CMP_WIDTH       = (SAMPLE_WIDTH > CFG_WIDTH) ? SAMPLE_WIDTH : CFG_WIDTH;
  localparam int PROD_WIDTH      = SAMPLE_WIDTH + CFG_WIDTH + 1;
  localparam int REG_INDEX_WIDTH = 3;

  // Queue between front and back
  localparam int FIFO_DEPTH     = 4;
  localparam int FIFO_PTR_WIDTH = $clog2(FIFO_DEPTH);

  // Register indexes
  localparam logic [REG_INDEX_WIDTH-1:0] REG_BITS_MODE       = 3'd0;
  localparam logic [REG_INDEX_WIDTH-1:0] REG_SAMPLE_MEAN     = 3'd1;
  localparam logic [REG_INDEX_WIDTH-1:0] REG_UPPER_THRESHOLD = 3'd2;
  localparam logic [REG_INDEX_WIDTH-1:0] REG_LOWER_THRESHOLD = 3'd3;
  localparam logic [REG_INDEX_WIDTH-1:0] REG_EIGHT_BIT_SCALE = 3'd4;

  // Register reset values
  localparam logic signed [CFG_WIDTH-1:0] MEAN_RESET  = 16'sd0;
  localparam logic signed [CFG_WIDTH-1:0] UPPER_RESET = 16'sd243;
  localparam logic signed [CFG_WIDTH-1:0] LOWER_RESET = -16'sd243;
  localparam logic [CFG_WIDTH-1:0]        SCALE_RESET = 16'd2560;

  // Two-bit codes
  localparam logic [1:0] CODE_LARGE_NEG = 2'd0;
  localparam logic [1:0] CODE_SMALL_NEG = 2'd1;
  localparam logic [1:0] CODE_SMALL_POS = 2'd2;
  localparam logic [1:0] CODE_LARGE_POS = 2'd3;

  // Eight-bit clip limits (+-127 in Q.16) and offset-binary bias (128 in Q.16)
  localparam logic signed [PROD_WIDTH-1:0] CLIP_HIGH   = PROD_WIDTH'(127 * 65536);
  localparam logic signed [PROD_WIDTH-1:0] CLIP_LOW    = PROD_WIDTH'(-127 * 65536);
  localparam logic signed [PROD_WIDTH-1:0] BYTE_OFFSET = PROD_WIDTH'(128 * 65536);
  localparam logic [15:0]                  ROUND_HALF  = 16'h8000;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           last_in_frame;
  } in_t;

  typedef struct packed {
    logic [7:0] packed_byte;
    logic       frame_end;
    logic       misaligned;
  } out_t;

  typedef struct packed {
    logic                        bits_mode;
    logic signed [CFG_WIDTH-1:0] sample_mean;
    logic signed [CFG_WIDTH-1:0] upper_threshold;
    logic signed [CFG_WIDTH-1:0] lower_threshold;
    logic [CFG_WIDTH-1:0]        eight_bit_scale;
  } cfg_t;

  // Classified beat carried from front to back
  typedef struct packed {
    logic                           eight;
    logic [1:0]                     code;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           last;
  } qent_t;

endpackage
`default_nettype wire

// ===== rtl/sample_quantizer_packer.sv =====
// Sample quantizer and byte packer.
// Item channel (item_valid/item_ready/item): one signed Q7.8 sample and a
// last-in-frame mark per beat. Result channel (result_valid/result_ready/
// result): one output byte with frame_end and misaligned flags per beat.
// Two-bit mode emits one byte per four samples (codes low first), or a
// partial byte flagged misaligned when a frame ends early. Eight-bit mode
// emits one offset-binary byte per sample.
// Throughput: one sample per cycle while the queue has room. A beat that
// completes a byte passes a 4-deep queue, a product register after the
// 16x17 multiplier, then the output register.
// Configuration (cfg_write/cfg_index/cfg_data) is written with no wait;
// the user writes it only while the block is idle, which the block does
// not enforce. Writing bits_mode drops pending codes. Synchronous reset
// loads the register defaults and empties queue, pipeline and pending
// codes. On a receiver stall the output register holds, the product
// stage and queue fill, and item_ready falls only when the queue is full.
`default_nettype none
module sample_quantizer_packer import sqp_pkg::*; (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_write,
  input  wire logic [REG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [CFG_WIDTH-1:0]       cfg_data,
  input  wire logic                       item_valid,
  output logic                            item_ready,
  input  wire in_t                        item,
  output logic                            result_valid,
  input  wire logic                       result_ready,
  output out_t                            result
);

  cfg_t  cfg;
  logic  mode_clear;
  logic  push;
  qent_t push_data;
  logic  fifo_full;
  logic  fifo_not_empty;
  logic  pop;
  qent_t pop_data;

  // Accept and classify
  sqp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .fifo_full  (fifo_full),
    .push       (push),
    .push_data  (push_data),
    .cfg        (cfg),
    .mode_clear (mode_clear)
  );

  // Decoupling queue
  sqp_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (fifo_full),
    .not_empty (fifo_not_empty)
  );

  // Pack, scale and deliver
  sqp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .mode_clear   (mode_clear),
    .pop_valid    (fifo_not_empty),
    .pop_data     (pop_data),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
`default_nettype wire

// ===== rtl/sqp_front.sv =====
`default_nettype none
module sqp_front import sqp_pkg::*; (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_write,
  input  wire logic [REG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [CFG_WIDTH-1:0]       cfg_data,
  input  wire logic                       item_valid,
  output logic                            item_ready,
  input  wire in_t                        item,
  input  wire logic                       fifo_full,
  output logic                            push,
  output qent_t                           push_data,
  output cfg_t                            cfg,
  output logic                            mode_clear
);

  logic signed [CMP_WIDTH-1:0] s_ext;
  logic signed [CMP_WIDTH-1:0] mean_ext;
  logic signed [CMP_WIDTH-1:0] upper_ext;
  logic signed [CMP_WIDTH-1:0] lower_ext;
  logic [1:0]                  code;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bits_mode       <= 1'b0;
      cfg.sample_mean     <= MEAN_RESET;
      cfg.upper_threshold <= UPPER_RESET;
      cfg.lower_threshold <= LOWER_RESET;
      cfg.eight_bit_scale <= SCALE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_BITS_MODE:       cfg.bits_mode       <= cfg_data[0];
        REG_SAMPLE_MEAN:     cfg.sample_mean     <= cfg_data;
        REG_UPPER_THRESHOLD: cfg.upper_threshold <= cfg_data;
        REG_LOWER_THRESHOLD: cfg.lower_threshold <= cfg_data;
        REG_EIGHT_BIT_SCALE: cfg.eight_bit_scale <= cfg_data;
        default: ;
      endcase
    end
  end

  // A mode write drops any partly built byte in the back end
  assign mode_clear = cfg_write && (cfg_index == REG_BITS_MODE);

  // Two-bit classification, checked in fixed order
  assign s_ext     = CMP_WIDTH'(item.sample);
  assign mean_ext  = CMP_WIDTH'(cfg.sample_mean);
  assign upper_ext = CMP_WIDTH'(cfg.upper_threshold);
  assign lower_ext = CMP_WIDTH'(cfg.lower_threshold);

  always_comb begin
    priority if (s_ext >= upper_ext) code = CODE_LARGE_POS;
    else if (s_ext <= lower_ext)     code = CODE_LARGE_NEG;
    else if (s_ext > mean_ext)       code = CODE_SMALL_POS;
    else                             code = CODE_SMALL_NEG;
  end

  // Beat goes straight into the queue when there is room
  assign item_ready       = !fifo_full;
  assign push             = item_valid && item_ready;
  assign push_data.eight  = cfg.bits_mode;
  assign push_data.code   = code;
  assign push_data.sample = item.sample;
  assign push_data.last   = item.last_in_frame;

endmodule
`default_nettype wire

// ===== rtl/sqp_fifo.sv =====
`default_nettype none
module sqp_fifo import sqp_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire qent_t push_data,
  input  wire logic  pop,
  output qent_t      pop_data,
  output logic       full,
  output logic       not_empty
);

  qent_t                     mem [FIFO_DEPTH];
  logic [FIFO_PTR_WIDTH-1:0] wr_ptr;
  logic [FIFO_PTR_WIDTH-1:0] rd_ptr;
  logic [FIFO_PTR_WIDTH:0]   count;

  assign full      = (count == (FIFO_PTR_WIDTH+1)'(FIFO_DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = mem[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

endmodule
`default_nettype wire

// ===== rtl/sqp_back.sv =====
`default_nettype none
module sqp_back import sqp_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cfg_t  cfg,
  input  wire logic  mode_clear,
  input  wire logic  pop_valid,
  input  wire qent_t pop_data,
  output logic       pop,
  output logic       result_valid,
  input  wire logic  result_ready,
  output out_t       result
);

  // Pending two-bit codes
  logic [5:0] pend_codes;
  logic [1:0] pend_cnt;

  // Product stage
  logic                          m_valid;
  logic                          m_eight;
  logic signed [PROD_WIDTH-1:0]  m_prod;
  logic [7:0]                    m_byte;
  logic                          m_last;
  logic                          m_mis;

  logic                          o_free;
  logic                          m_ready;
  logic [7:0]                    byte_pack;
  logic                          pack_emit;
  logic signed [PROD_WIDTH-1:0]  prod_next;
  logic signed [PROD_WIDTH-1:0]  clipped;
  logic signed [PROD_WIDTH-1:0]  biased;
  logic [7:0]                    int_part;
  logic [15:0]                   frac_part;
  logic                          round_up;
  logic [7:0]                    scaled;

  assign o_free  = !result_valid || result_ready;
  assign m_ready = !m_valid || o_free;
  assign pop     = pop_valid && m_ready;

  // Merge the new code above the pending ones
  assign byte_pack = {2'b00, pend_codes} | (8'(pop_data.code) << {pend_cnt, 1'b0});
  assign pack_emit = (pend_cnt == 2'd3) || pop_data.last;

  assign prod_next = $signed(pop_data.sample) * $signed({1'b0, cfg.eight_bit_scale});

  // Pack state
  always_ff @(posedge clk) begin
    if (rst || mode_clear) begin
      pend_codes <= '0;
      pend_cnt   <= '0;
    end else if (pop && !pop_data.eight) begin
      if (pack_emit) begin
        pend_codes <= '0;
        pend_cnt   <= '0;
      end else begin
        pend_codes <= byte_pack[5:0];
        pend_cnt   <= pend_cnt + 1'b1;
      end
    end
  end

  // Product stage: only beats that make a byte enter it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (m_ready) begin
      m_valid <= pop && (pop_data.eight || pack_emit);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      m_eight <= pop_data.eight;
      m_prod  <= prod_next;
      m_byte  <= byte_pack;
      m_last  <= pop_data.last;
      m_mis   <= (pend_cnt != 2'd3);
    end
  end

  // Clip to +-127, bias to offset binary, round half to even
  always_comb begin
    priority if (m_prod > CLIP_HIGH) clipped = CLIP_HIGH;
    else if (m_prod < CLIP_LOW)      clipped = CLIP_LOW;
    else                             clipped = m_prod;
  end

  assign biased    = clipped + BYTE_OFFSET;
  assign int_part  = biased[23:16];
  assign frac_part = biased[15:0];
  assign round_up  = (frac_part > ROUND_HALF) || ((frac_part == ROUND_HALF) && int_part[0]);
  assign scaled    = int_part + 8'(round_up);

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (o_free) begin
      result_valid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (o_free && m_valid) begin
      result.packed_byte <= m_eight ? scaled : m_byte;
      result.frame_end   <= m_last;
      result.misaligned  <= m_eight ? 1'b0 : m_mis;
    end
  end

`ifndef SYNTH
  a_mis_is_end: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.misaligned |-> result.frame_end)
    else $error("misaligned byte without frame end");

  a_mis_top_empty: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.misaligned |-> result.packed_byte[7:6] == 2'b00)
    else $error("partial byte has a code in its top position");

  a_pend_clean: assert property (@(posedge clk) disable iff (rst)
    pend_cnt == 2'd0 |-> pend_codes == 6'd0)
    else $error("stale pending codes with empty count");

  a_eight_keeps: assert property (@(posedge clk) disable iff (rst)
    pop && pop_data.eight && !mode_clear |=> pend_cnt == $past(pend_cnt))
    else $error("eight-bit beat disturbed pending codes");
`endif

endmodule
`default_nettype wire

// ===== test/sample_quantizer_packer_tb.sv =====
module sample_quantizer_packer_tb;
  import sqp_pkg::*;

  localparam int HALF_PERIOD = 5;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 12;
  localparam int PRINT_CAP = 30;
  localparam longint CLIP_Q16 = 127 * 65536;
  localparam longint BIAS_Q16 = 128 * 65536;
  localparam longint FRAC_MASK = 'hFFFF;
  localparam longint FRAC_HALF = 'h8000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [REG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [CFG_WIDTH-1:0] cfg_data = '0;
  logic item_valid = 1'b0;
  logic item_ready;
  in_t item = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  out_t result;

  // Predictor copy of the registers and the packing state
  logic mode_q = 1'b0;
  logic signed [CFG_WIDTH-1:0] mean_q = MEAN_RESET;
  logic signed [CFG_WIDTH-1:0] upper_q = UPPER_RESET;
  logic signed [CFG_WIDTH-1:0] lower_q = LOWER_RESET;
  logic [CFG_WIDTH-1:0] scale_q = SCALE_RESET;
  logic [5:0] held_codes = '0;
  logic [1:0] held_count = '0;

  in_t outgoing_samples[$];
  out_t expected_bytes[$];
  int mismatch_count = 0;
  int cycle_count = 0;
  bit item_taken = 1'b0;
  int send_gap = 0;
  int recv_stall = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  sample_quantizer_packer dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
  endfunction

  // Quantize or scale one accepted sample; queue the byte it completes
  task automatic predict_byte(input in_t beat);
    out_t want;
    logic [1:0] code;
    logic [7:0] merged;
    longint prod, whole, frac;
    if (mode_q) begin
      prod = longint'($signed(beat.sample)) * longint'(scale_q);
      if (prod > CLIP_Q16) prod = CLIP_Q16;
      if (prod < -CLIP_Q16) prod = -CLIP_Q16;
      prod = prod + BIAS_Q16;
      whole = prod >>> 16;
      frac = prod & FRAC_MASK;
      // round half to even
      if (frac > FRAC_HALF || (frac == FRAC_HALF && whole[0])) whole = whole + 1;
      want.packed_byte = whole[7:0];
      want.frame_end = beat.last_in_frame;
      want.misaligned = 1'b0;
      expected_bytes.push_back(want);
    end else begin
      if (beat.sample >= upper_q) code = CODE_LARGE_POS;
      else if (beat.sample <= lower_q) code = CODE_LARGE_NEG;
      else if (beat.sample > mean_q) code = CODE_SMALL_POS;
      else code = CODE_SMALL_NEG;
      merged = {2'b00, held_codes} | (8'(code) << (2 * held_count));
      if (held_count == 2'd3) begin
        want.packed_byte = merged;
        want.frame_end = beat.last_in_frame;
        want.misaligned = 1'b0;
        expected_bytes.push_back(want);
        held_codes = '0;
        held_count = '0;
      end else if (beat.last_in_frame) begin
        // short frame: flush partial byte
        want.packed_byte = merged;
        want.frame_end = 1'b1;
        want.misaligned = 1'b1;
        expected_bytes.push_back(want);
        held_codes = '0;
        held_count = '0;
      end else begin
        held_codes = merged[5:0];
        held_count = held_count + 2'd1;
      end
    end
  endtask

  // Sample picker: full range, near the levels, rails, and typical amplitudes
  function automatic logic signed [SAMPLE_WIDTH-1:0] pick_sample();
    int r;
    logic signed [SAMPLE_WIDTH-1:0] jitter;
    r = $urandom_range(0, 99);
    jitter = SAMPLE_WIDTH'($urandom_range(0, 8)) - SAMPLE_WIDTH'(4);
    if (r < 25) return SAMPLE_WIDTH'($urandom);
    else if (r < 35) return upper_q + jitter;
    else if (r < 45) return lower_q + jitter;
    else if (r < 55) return mean_q + jitter;
    else if (r < 60) return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
    else return SAMPLE_WIDTH'($urandom_range(0, 4096)) - SAMPLE_WIDTH'(2048);
  endfunction

  task automatic push_beat(input logic signed [SAMPLE_WIDTH-1:0] value, input logic last);
    in_t beat;
    beat.sample = value;
    beat.last_in_frame = last;
    outgoing_samples.push_back(beat);
  endtask

  // Mostly whole frames of four-code multiples, some short frames, some noise
  task automatic queue_frames(input int count);
    int queued, len, kind;
    bit noisy;
    queued = 0;
    while (queued < count) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) len = 4 * $urandom_range(1, 6);
      else len = $urandom_range(1, 11);
      noisy = (kind >= 90);
      for (int i = 0; i < len; i++) begin
        push_beat(pick_sample(), noisy ? ($urandom_range(0, 3) == 0) : (i == len - 1));
      end
      queued += len;
    end
  endtask

  // Register write; predictor copy follows at the same edge
  task automatic write_reg(input logic [REG_INDEX_WIDTH-1:0] idx,
                           input logic [CFG_WIDTH-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_BITS_MODE: begin
        mode_q = data[0];
        held_codes = '0;
        held_count = '0;
      end
      REG_SAMPLE_MEAN: mean_q = data;
      REG_UPPER_THRESHOLD: upper_q = data;
      REG_LOWER_THRESHOLD: lower_q = data;
      REG_EIGHT_BIT_SCALE: scale_q = data;
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // All beats sent and every expected byte back
  task automatic wait_idle();
    while (outgoing_samples.size() != 0 || item_valid || expected_bytes.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Idle plus time for samples that produce no byte to clear the pipeline
  task automatic settle();
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apply_settings(input int p);
    logic mode, write_mode;
    logic signed [CFG_WIDTH-1:0] mid, spread, upper, lower;
    logic [CFG_WIDTH-1:0] gain;
    mid = ($urandom_range(0, 3) == 0) ? CFG_WIDTH'($urandom)
                                      : CFG_WIDTH'($urandom_range(0, 400)) - CFG_WIDTH'(200);
    spread = CFG_WIDTH'($urandom_range(8, 1500));
    mode = 1'($urandom_range(0, 1));
    write_mode = ($urandom_range(0, 2) != 0);
    upper = mid + spread;
    lower = mid - spread;
    case ($urandom_range(0, 3))
      0: gain = CFG_WIDTH'($urandom);
      1: gain = SCALE_RESET;
      default: gain = CFG_WIDTH'($urandom_range(32, 4096));
    endcase
    case (p)
      0: begin
        // rails: almost every sample lands in the middle codes
        write_mode = 1'b1;
        mode = 1'b0;
        mid = 16'sh8000;
        upper = 16'sh7FFF;
        lower = 16'sh8000;
      end
      1: begin
        write_mode = 1'b1;
        mode = 1'b1;
        gain = 16'hFFFF;
      end
      2: begin
        write_mode = 1'b1;
        mode = 1'b1;
        gain = '0;
      end
      3: begin
        // crossed thresholds
        write_mode = 1'b1;
        mode = 1'b0;
        mid = '0;
        upper = -16'sd100;
        lower = 16'sd100;
      end
      default: begin
        if ($urandom_range(0, 4) == 0) begin
          upper = CFG_WIDTH'($urandom);
          lower = CFG_WIDTH'($urandom);
        end
      end
    endcase
    if (write_mode) write_reg(REG_BITS_MODE, CFG_WIDTH'(mode));
    write_reg(REG_SAMPLE_MEAN, mid);
    write_reg(REG_UPPER_THRESHOLD, upper);
    write_reg(REG_LOWER_THRESHOLD, lower);
    write_reg(REG_EIGHT_BIT_SCALE, gain);
    end_writes();
  endtask

  // Sample driver: new beat only once the previous one is taken
  always @(negedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || item_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        item_valid <= 1'b0;
      end else if (outgoing_samples.size() > 0) begin
        item <= outgoing_samples.pop_front();
        item_valid <= 1'b1;
        send_gap = ($urandom_range(0, 99) < send_idle_pct) ? pick_gap() : 0;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // Receiver backpressure
  always @(negedge clk) begin
    if (recv_stall > 0) begin
      recv_stall--;
      result_ready <= 1'b0;
    end else begin
      result_ready <= 1'b1;
      if ($urandom_range(0, 99) < recv_stall_pct) recv_stall = pick_gap();
    end
  end

  // Monitor: compare output beats, predict from accepted input beats
  always @(posedge clk) begin : check_results
    out_t want;
    cycle_count++;
    item_taken = item_valid && item_ready;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("sample_quantizer_packer_tb: FAIL");
      $finish;
    end else if (!rst) begin
      if (result_valid && result_ready) begin
        if (expected_bytes.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= PRINT_CAP)
            $display("%0t: unexpected byte: expected none, actual %h fe=%b mis=%b",
                     $time, result.packed_byte, result.frame_end, result.misaligned);
        end else begin
          want = expected_bytes.pop_front();
          if (result.packed_byte !== want.packed_byte) begin
            mismatch_count++;
            if (mismatch_count <= PRINT_CAP)
              $display("%0t: packed_byte expected %h actual %h",
                       $time, want.packed_byte, result.packed_byte);
          end
          if (result.frame_end !== want.frame_end) begin
            mismatch_count++;
            if (mismatch_count <= PRINT_CAP)
              $display("%0t: frame_end expected %b actual %b",
                       $time, want.frame_end, result.frame_end);
          end
          if (result.misaligned !== want.misaligned) begin
            mismatch_count++;
            if (mismatch_count <= PRINT_CAP)
              $display("%0t: misaligned expected %b actual %b",
                       $time, want.misaligned, result.misaligned);
          end
        end
      end
      if (item_taken) predict_byte(item);
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Two-bit mode at reset levels: every code, both rails
    push_beat(16'sd243, 1'b0);
    push_beat(16'sd242, 1'b0);
    push_beat(16'sd1, 1'b0);
    push_beat(16'sd0, 1'b0);
    push_beat(-16'sd242, 1'b0);
    push_beat(-16'sd243, 1'b0);
    push_beat(16'sh7FFF, 1'b0);
    push_beat(16'sh8000, 1'b0);
    // frame end on the fourth code: full byte
    push_beat(16'sd300, 1'b0);
    push_beat(-16'sd300, 1'b0);
    push_beat(16'sd10, 1'b0);
    push_beat(-16'sd10, 1'b1);
    // short frames: two codes, then one
    push_beat(16'sd100, 1'b0);
    push_beat(-16'sd100, 1'b1);
    push_beat(-16'sd300, 1'b1);
    settle();

    // Held codes survive writes to unused indexes
    push_beat(16'sd500, 1'b0);
    push_beat(-16'sd500, 1'b0);
    settle();
    for (int i = REG_EIGHT_BIT_SCALE + 1; i < 2 ** REG_INDEX_WIDTH; i++) begin
      write_reg(REG_INDEX_WIDTH'(i), '1);
    end
    end_writes();
    push_beat(16'sd50, 1'b1);
    settle();

    // Mode write drops held codes
    push_beat(16'sd500, 1'b0);
    push_beat(16'sd500, 1'b0);
    settle();
    write_reg(REG_BITS_MODE, '0);
    end_writes();
    push_beat(-16'sd500, 1'b1);
    settle();

    // Eight-bit mode, unity gain: ties to even, clipping
    write_reg(REG_BITS_MODE, CFG_WIDTH'(1));
    write_reg(REG_EIGHT_BIT_SCALE, CFG_WIDTH'(256));
    end_writes();
    push_beat(16'sh0180, 1'b0);
    push_beat(16'sh0280, 1'b0);
    push_beat(-16'sh0180, 1'b0);
    push_beat(16'sh7FFF, 1'b0);
    push_beat(16'sh8000, 1'b0);
    push_beat(16'sh0000, 1'b1);
    settle();

    // Random phases, each with its own settings and idle pattern
    for (int p = 0; p < 11; p++) begin
      apply_settings(p);
      case ($urandom_range(0, 2))
        0: send_idle_pct = 0;
        1: send_idle_pct = 20;
        default: send_idle_pct = 50;
      endcase
      case ($urandom_range(0, 2))
        0: recv_stall_pct = 0;
        1: recv_stall_pct = 20;
        default: recv_stall_pct = 50;
      endcase
      queue_frames(22);
      // sender holds until every byte so far is back
      if (p % 2 == 1) wait_idle();
      queue_frames(22);
      settle();
    end

    if (mismatch_count == 0) begin
      $display("sample_quantizer_packer_tb: PASS");
    end else begin
      $display("sample_quantizer_packer_tb: FAIL");
    end
    $finish;
  end

endmodule
